/* rtl/core/aes_pkg.sv */
// Package for the AES-128 encryption pipeline: payload types, S-box, GF(2^8) helpers.
// No dependencies.
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd1;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Byte i of a 128-bit word, byte 0 in the top bits.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key from the current one.
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

/* rtl/core/aes_round_cell.sv */
// One round cell of the encryption pipeline: round logic plus next round key.
// Depends on aes_pkg.
module aes_round_cell #(
    parameter bit LAST = 1'b0
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [7:0]   rcon,
    input  logic [127:0] state_in,
    input  logic [127:0] key_in,
    output logic [127:0] state_out,
    output logic [127:0] key_out
);
    import aes_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [127:0] key_reg, key_next;
    logic [127:0] sub_sh;
    logic [127:0] mixed;

    // SubBytes and ShiftRows
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sub_sh[127-8*(4*c+r) -: 8] = SBOX[get_byte(state_in, 4*((c+r)%4)+r)];
            end
        end
    end

    // MixColumns, skipped in the final round
    always_comb begin
        logic [7:0] a0, a1, a2, a3, al;
        mixed = sub_sh;
        if (!LAST) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(sub_sh, 4*c);
                a1 = get_byte(sub_sh, 4*c+1);
                a2 = get_byte(sub_sh, 4*c+2);
                a3 = get_byte(sub_sh, 4*c+3);
                al = a0 ^ a1 ^ a2 ^ a3;
                mixed[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                mixed[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                mixed[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                mixed[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
    end

    assign key_next   = next_key(key_in, rcon);
    assign state_next = mixed ^ key_next;

    // Advance when the pipeline moves
    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule

/* rtl/core/aes128_block_encrypt.sv */
// AES-128 encryption top level: key registers, input stage and ten round cells.
// Depends on aes_pkg and aes_round_cell.
// Datapath: the registered input stage (initial AddRoundKey), then the ten round cells in order.
// Throughput: one block per cycle; each round cell is a pipeline stage and the whole
// chain advances whenever the output stage is empty or being taken.
// Reset: synchronous active-low aresetn clears the key registers and all valid bits.
module aes128_block_encrypt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  aes_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output aes_pkg::out_item_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import aes_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg;
    logic [NUM_ROUNDS:0] vld_reg, vld_next;
    logic [127:0] st_reg;
    logic [127:0] key0_reg;
    logic [127:0] st_chain [NUM_ROUNDS+1];
    logic [127:0] key_chain [NUM_ROUNDS+1];
    logic         adv;

    assign cfg_ready = 1'b1;

    // Hold the cipher key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_KEY_HIGH) key_high_reg <= cfg_data;
            if (cfg_index == CFG_KEY_LOW)  key_low_reg  <= cfg_data;
        end
    end

    // Whole chain advances unless the output stage is full and stalled
    assign adv     = !vld_reg[NUM_ROUNDS] || m_ready;
    assign s_ready = adv;

    always_comb begin
        vld_next = vld_reg;
        if (adv) vld_next = {vld_reg[NUM_ROUNDS-1:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else          vld_reg <= vld_next;
    end

    // Input stage: initial AddRoundKey
    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg   <= {s_data.plain_high, s_data.plain_low} ^ {key_high_reg, key_low_reg};
            key0_reg <= {key_high_reg, key_low_reg};
        end
    end

    assign st_chain[0]  = st_reg;
    assign key_chain[0] = key0_reg;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round_cell #(.LAST(g == NUM_ROUNDS-1)) u_cell (
            .aclk      (aclk),
            .en        (adv),
            .rcon      (RCON[g]),
            .state_in  (st_chain[g]),
            .key_in    (key_chain[g]),
            .state_out (st_chain[g+1]),
            .key_out   (key_chain[g+1])
        );
    end

    assign m_valid            = vld_reg[NUM_ROUNDS];
    assign m_data.cipher_high = st_chain[NUM_ROUNDS][127:64];
    assign m_data.cipher_low  = st_chain[NUM_ROUNDS][63:0];

endmodule
